[hdl/smte_pkg.sv]
package smte_pkg;
    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_BITS = $clog2(STACK_DEPTH);
    localparam int CNT_BITS = ADDR_BITS + 1;
    localparam int PC_BITS = 16;
    localparam int DATA_BITS = 64;

    localparam logic [3:0] FN_NONE = 4'd0;
    localparam logic [3:0] FN_PUSH = 4'd1;
    localparam logic [3:0] FN_ADD  = 4'd2;
    localparam logic [3:0] FN_SUB  = 4'd3;
    localparam logic [3:0] FN_MUL  = 4'd4;
    localparam logic [3:0] FN_DIV  = 4'd5;
    localparam logic [3:0] FN_JMP  = 4'd6;
    localparam logic [3:0] FN_CMP  = 4'd7;
    localparam logic [3:0] FN_JCMP = 4'd8;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NONE      = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;
    localparam logic [2:0] ST_DIVZERO   = 3'd5;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [63:0] operand;
    } t_token;

    typedef struct packed {
        logic [PC_BITS-1:0]  next_pc;
        logic signed [63:0]  top_value;
        logic [CNT_BITS-1:0] depth;
        logic [2:0]          status;
    } t_result;
endpackage

[hdl/smte_if.sv]
interface smte_in_if (input logic i_clk);
    import smte_pkg::*;
    logic   valid;
    logic   ready;
    t_token payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface smte_out_if (input logic i_clk);
    import smte_pkg::*;
    logic    valid;
    logic    ready;
    t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hdl/stack_machine_token_executor.sv]
// Push writes the operand and finishes; jump, none, invalid, underflow and overflow
// only reread the top; add/sub/mul/div/compare read the operands, execute and write
// back; jumpcompare pops two and divide by zero stops, and both then reread the top.
// Mul runs 32 steps of 2 bits, div 64 steps of 1 bit. One request at a time: the next
// is accepted in the cycle after the result is taken, as a single FSM runs every operation.
// Reset: synchronous active low; clears depth, program counter and control, not the RAM.
module stack_machine_token_executor (
    input  logic i_clk,
    input  logic i_rst_n,
    smte_in_if.sink    i_tok,
    smte_out_if.source o_res
);
    import smte_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_RD_T, S_RD_S, S_EXEC, S_ITER, S_FIN, S_WR, S_TOP, S_TOPW, S_OUT
    } t_state;

    t_state                r_state;
    logic [3:0]            r_func;
    logic [63:0]           r_opnd;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [PC_BITS-1:0]    r_pc;
    logic [2:0]            r_status;
    logic [63:0]           r_t, r_s, r_acc, r_rem, r_q;
    logic [6:0]            r_iter;
    logic                  r_neg;
    logic [63:0]           r_top;
    logic [ADDR_BITS-1:0]  r_raddr;
    logic [63:0]           r_rdata;
    logic                  r_we;
    logic [ADDR_BITS-1:0]  r_waddr;
    logic [63:0]           r_wdata;
    logic [63:0]           mem [STACK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (r_we) mem[r_waddr] <= r_wdata;
        r_rdata <= mem[r_raddr];
    end

    logic [64:0] w_diff;
    logic [63:0] w_rem_sh;
    logic [63:0] w_addend;
    assign w_rem_sh = {r_rem[62:0], r_q[63]};
    assign w_diff = {1'b0, w_rem_sh} - {1'b0, r_s};
    always_comb begin
        w_addend = '0;
        case (r_t[1:0])
            2'd1: w_addend = r_s;
            2'd2: w_addend = {r_s[62:0], 1'b0};
            2'd3: w_addend = {r_s[62:0], 1'b0} + r_s;
            default: w_addend = '0;
        endcase
    end

    logic [CNT_BITS-1:0] w_cnt_m1;
    assign w_cnt_m1 = r_cnt - 1'b1;

    assign i_tok.ready = (r_state == S_IDLE);
    assign o_res.valid = (r_state == S_OUT);
    assign o_res.payload.next_pc = r_pc;
    assign o_res.payload.top_value = (r_cnt == '0) ? 64'sd0 : r_top;
    assign o_res.payload.depth = r_cnt;
    assign o_res.payload.status = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pc    <= '0;
            r_we    <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_we <= 1'b0;
            case (r_state)
                S_IDLE: if (i_tok.valid) begin
                    r_func <= i_tok.payload.func;
                    r_opnd <= i_tok.payload.operand;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_status <= ST_OK;
                    r_raddr <= w_cnt_m1[ADDR_BITS-1:0];
                    r_state <= S_TOP;
                    case (r_func)
                        FN_NONE: r_status <= ST_NONE;
                        FN_PUSH: if (r_cnt >= CNT_BITS'(STACK_DEPTH)) begin
                            r_status <= ST_OVERFLOW;
                        end else begin
                            r_we <= 1'b1;
                            r_waddr <= r_cnt[ADDR_BITS-1:0];
                            r_wdata <= r_opnd;
                            r_top <= r_opnd;
                            r_cnt <= r_cnt + 1'b1;
                            r_state <= S_FIN;
                        end
                        FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_JCMP:
                            if (r_cnt < CNT_BITS'(2)) r_status <= ST_UNDERFLOW;
                            else r_state <= S_RD_T;
                        FN_JMP: r_pc <= r_opnd[PC_BITS-1:0];
                        FN_CMP:
                            if (r_cnt < CNT_BITS'(1)) r_status <= ST_UNDERFLOW;
                            else r_state <= S_RD_T;
                        default: r_status <= ST_INVALID;
                    endcase
                end
                S_RD_T: begin
                    r_raddr <= r_cnt[ADDR_BITS-1:0] - ADDR_BITS'(2);
                    r_state <= S_RD_S;
                end
                S_RD_S: begin
                    r_t <= r_rdata;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_s <= r_rdata;
                    r_state <= S_WR;
                    case (r_func)
                        FN_ADD: r_acc <= r_t + r_rdata;
                        FN_SUB: r_acc <= r_t - r_rdata;
                        FN_MUL: begin
                            r_acc <= '0; r_iter <= 7'd32; r_state <= S_ITER;
                        end
                        FN_DIV: if (r_rdata == '0) begin
                            r_status <= ST_DIVZERO;
                            r_raddr <= w_cnt_m1[ADDR_BITS-1:0];
                            r_state <= S_TOP;
                        end else begin
                            r_neg <= r_t[63] ^ r_rdata[63];
                            r_q <= r_t[63] ? -r_t : r_t;
                            r_s <= r_rdata[63] ? -r_rdata : r_rdata;
                            r_rem <= '0; r_iter <= 7'd64; r_state <= S_ITER;
                        end
                        FN_CMP: r_acc <= (r_t == r_opnd) ? 64'd1 : 64'd0;
                        default: begin
                            if (r_t == r_rdata) r_pc <= r_opnd[PC_BITS-1:0];
                            r_cnt <= r_cnt - CNT_BITS'(2);
                            r_raddr <= r_cnt[ADDR_BITS-1:0] - ADDR_BITS'(3);
                            r_state <= S_TOP;
                        end
                    endcase
                end
                S_ITER: begin
                    r_iter <= r_iter - 1'b1;
                    if (r_func == FN_MUL) begin
                        r_acc <= r_acc + w_addend;
                        r_t <= {2'b00, r_t[63:2]};
                        r_s <= {r_s[61:0], 2'b00};
                    end else begin
                        if (!w_diff[64]) r_rem <= w_diff[63:0];
                        else r_rem <= w_rem_sh;
                        r_q <= {r_q[62:0], ~w_diff[64]};
                    end
                    if (r_iter == 7'd1) begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_we <= 1'b1;
                    if (r_func == FN_CMP) begin
                        r_waddr <= w_cnt_m1[ADDR_BITS-1:0];
                    end else begin
                        r_waddr <= r_cnt[ADDR_BITS-1:0] - ADDR_BITS'(2);
                        r_cnt <= w_cnt_m1;
                    end
                    if (r_func == FN_DIV) begin
                        r_wdata <= r_neg ? -r_q : r_q;
                        r_top <= r_neg ? -r_q : r_q;
                    end else begin
                        r_wdata <= r_acc;
                        r_top <= r_acc;
                    end
                    r_state <= S_FIN;
                end
                S_TOP: r_state <= S_TOPW;
                S_TOPW: begin
                    r_top <= r_rdata;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_pc <= r_pc + 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (o_res.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
